// ===== src/trs_pkg.sv =====
`default_nettype none

package trs_pkg;

	localparam int CAPACITY = 64;
	localparam int DEPTH = CAPACITY;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KEY_W = 27;
	localparam int CNT_W = 7;
	localparam int DIM_W = 11;
	localparam int FMT_W = 3;
	localparam int MODE_W = 3;

	localparam logic [MODE_W-1:0] MODE_CONTAINS = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD = 3'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LIST = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic exec;
		logic list_step;
	} trs_cmd_t;

	typedef struct packed {
		logic mode_is_list;
		logic list_nonempty;
		logic list_last;
	} trs_status_t;

endpackage

`default_nettype wire

// ===== src/trs_ctrl.sv =====
`default_nettype none

module trs_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  trs_pkg::trs_status_t status,
	output trs_pkg::trs_cmd_t    cmd
);
	import trs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOKUP = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_LIST = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;
	logic       list_go;

	assign list_go = status.mode_is_list && status.list_nonempty;

	always_comb begin
		case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_LOOKUP: busy = 1'b1;
			ST_EXEC:   busy = list_go;
			ST_LIST:   busy = !status.list_last;
			default:   busy = 1'b1;
		endcase
	end

	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: state_d = ST_EXEC;
			ST_EXEC: begin
				if (list_go) state_d = ST_LIST;
				else if (accept) state_d = ST_LOOKUP;
				else state_d = ST_IDLE;
			end
			ST_LIST: begin
				if (status.list_last) state_d = accept ? ST_LOOKUP : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.load = accept;
	assign cmd.lookup = (state_q == ST_LOOKUP);
	assign cmd.exec = (state_q == ST_EXEC);
	assign cmd.list_step = (state_q == ST_LIST);

endmodule

`default_nettype wire

// ===== src/trs_dp.sv =====
`default_nettype none

module trs_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  trs_pkg::trs_cmd_t    cmd,
	output trs_pkg::trs_status_t status,
	input  wire  [2:0]           mode,
	input  wire  [2:0]           tex_format,
	input  wire  [10:0]          pos_x,
	input  wire  [10:0]          pos_y,
	input  wire  [10:0]          size_w,
	input  wire  [10:0]          size_h,
	output logic                 result_strobe,
	output logic                 present,
	output logic                 accepted,
	output logic                 overflow,
	output logic [6:0]           entry_count,
	output logic                 entry_valid,
	output logic [2:0]           out_format,
	output logic [10:0]          out_x,
	output logic [10:0]          out_y,
	output logic [10:0]          out_w,
	output logic [10:0]          out_h,
	output logic                 last
);
	import trs_pkg::*;

	logic [MODE_W-1:0] mode_q;
	key_t              key_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	key_t              store_q [DEPTH];
	key_t              store_d [DEPTH];
	key_t              up_w [DEPTH];
	logic [DEPTH-1:0]  match_w;
	logic [DEPTH-1:0]  match_s1;
	logic [IDX_W-1:0]  pos_w;
	logic [IDX_W-1:0]  list_idx_q;
	logic              hit;
	logic              full;
	logic              do_add;
	logic              do_remove;
	logic              emit_exec;

	logic              strobe_q;
	logic              present_q;
	logic              accepted_q;
	logic              overflow_q;
	logic              entry_valid_q;
	logic              last_q;
	logic [CNT_W-1:0]  entry_count_q;
	key_t              out_key_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match_w[i] = (CNT_W'(i) < count_q) && (store_q[i] == key_q);
		end
	end

	always_comb begin
		pos_w = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match_s1[i]) pos_w = pos_w | IDX_W'(i);
		end
	end

	assign hit = |match_s1;
	assign full = (count_q >= CNT_W'(CAPACITY));
	assign do_add = cmd.exec && (mode_q == MODE_ADD) && !hit && !full;
	assign do_remove = cmd.exec && (mode_q == MODE_REMOVE) && hit;
	assign emit_exec = cmd.exec && !((mode_q == MODE_LIST) && (count_q != '0));

	always_comb begin
		for (int i = 0; i < DEPTH - 1; i++) begin
			up_w[i] = store_q[i+1];
		end
		up_w[DEPTH-1] = store_q[DEPTH-1];
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			store_d[i] = store_q[i];
			if (do_add && (count_q[IDX_W-1:0] == IDX_W'(i))) begin
				store_d[i] = key_q;
			end else if (do_remove && (IDX_W'(i) >= pos_w)) begin
				store_d[i] = up_w[i];
			end else if (cmd.list_step) begin
				if (CNT_W'(i) + CNT_W'(1) == count_q) store_d[i] = store_q[0];
				else if (CNT_W'(i) + CNT_W'(1) < count_q) store_d[i] = up_w[i];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.exec) begin
			case (mode_q)
				MODE_ADD:    if (do_add) count_d = count_q + CNT_W'(1);
				MODE_REMOVE: if (do_remove) count_d = count_q - CNT_W'(1);
				MODE_CLEAR:  count_d = '0;
				default:     count_d = count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			key_q <= {tex_format, pos_x[10:5], pos_y[10:5], size_w[10:5], size_h[10:5]};
		end
		if (cmd.lookup) match_s1 <= match_w;
		for (int i = 0; i < DEPTH; i++) begin
			store_q[i] <= store_d[i];
		end
		if (cmd.exec) list_idx_q <= '0;
		else if (cmd.list_step) list_idx_q <= list_idx_q + IDX_W'(1);
		if (emit_exec) begin
			present_q <= hit && (mode_q inside {MODE_CONTAINS, MODE_ADD, MODE_REMOVE});
			accepted_q <= ((mode_q == MODE_ADD) && (hit || !full)) || do_remove;
			overflow_q <= (mode_q == MODE_ADD) && !hit && full;
			entry_count_q <= count_d;
			entry_valid_q <= 1'b0;
			out_key_q <= '0;
			last_q <= 1'b1;
		end else if (cmd.list_step) begin
			present_q <= 1'b0;
			accepted_q <= 1'b0;
			overflow_q <= 1'b0;
			entry_count_q <= count_q;
			entry_valid_q <= 1'b1;
			out_key_q <= store_q[0];
			last_q <= status.list_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			count_q <= count_d;
			strobe_q <= emit_exec || cmd.list_step;
		end
	end

	assign status.mode_is_list = (mode_q == MODE_LIST);
	assign status.list_nonempty = (count_q != '0);
	assign status.list_last = (CNT_W'(list_idx_q) + CNT_W'(1) >= count_q);

	assign result_strobe = strobe_q;
	assign present = present_q;
	assign accepted = accepted_q;
	assign overflow = overflow_q;
	assign entry_count = entry_count_q;
	assign entry_valid = entry_valid_q;
	assign last = last_q;
	assign out_format = out_key_q[26:24];
	assign out_x = {out_key_q[23:18], 5'b0};
	assign out_y = {out_key_q[17:12], 5'b0};
	assign out_w = {out_key_q[11:6], 5'b0};
	assign out_h = {out_key_q[5:0], 5'b0};

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored count exceeds capacity");

	a_unique_keys: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $onehot0(match_s1))
		else $error("key found in more than one entry");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && overflow_q |-> !accepted_q && (entry_count_q == CNT_W'(CAPACITY)))
		else $error("overflow reported on a set that is not full");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("add did not grow the count");
`endif

endmodule

`default_nettype wire

// ===== src/texture_reference_set.sv =====
`default_nettype none

// Channel    Handshake                 Words
// command    start, busy               mode, tex_format, pos_x, pos_y, size_w, size_h
// result     result_strobe (1 cycle)   present, accepted, overflow, entry_count,
//                                      entry_valid, out_format, out_x..out_h, last
//
// A command word passes through a lookup state, which compares its key against every stored
// entry, and an exec state, which updates the store and registers the result; the result
// appears on the following cycle. A list emits one result word per cycle while the store
// rotates; busy stays high until its last word is on the way.
// Reset empties the set; the stored keys themselves are not cleared.
// Results are shown for one cycle only and cannot be held off by the receiver.

module texture_reference_set (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  mode,
	input  wire  [2:0]  tex_format,
	input  wire  [10:0] pos_x,
	input  wire  [10:0] pos_y,
	input  wire  [10:0] size_w,
	input  wire  [10:0] size_h,
	output logic        result_strobe,
	output logic        present,
	output logic        accepted,
	output logic        overflow,
	output logic [6:0]  entry_count,
	output logic        entry_valid,
	output logic [2:0]  out_format,
	output logic [10:0] out_x,
	output logic [10:0] out_y,
	output logic [10:0] out_w,
	output logic [10:0] out_h,
	output logic        last
);
	import trs_pkg::*;

	trs_cmd_t    cmd;
	trs_status_t status;

	trs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	trs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.mode          (mode),
		.tex_format    (tex_format),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.size_w        (size_w),
		.size_h        (size_h),
		.result_strobe (result_strobe),
		.present       (present),
		.accepted      (accepted),
		.overflow      (overflow),
		.entry_count   (entry_count),
		.entry_valid   (entry_valid),
		.out_format    (out_format),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_w         (out_w),
		.out_h         (out_h),
		.last          (last)
	);

endmodule

`default_nettype wire

// ===== tb/texture_reference_set_tb.sv =====
`default_nettype none

module texture_reference_set_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import trs_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;
	localparam int STALL_LIMIT = 400;
	localparam int DRAIN_CYCLES = 10;
	localparam int POOL_MAX = 16;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [FMT_W-1:0]  fmt;
		logic [DIM_W-1:0]  x;
		logic [DIM_W-1:0]  y;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
	} set_word_t;

	typedef struct packed {
		logic              present;
		logic              accepted;
		logic              overflow;
		logic [CNT_W-1:0]  entry_count;
		logic              entry_valid;
		logic [FMT_W-1:0]  fmt;
		logic [DIM_W-1:0]  x;
		logic [DIM_W-1:0]  y;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic              last;
	} set_reply_t;

	class reference_set_tracker;
		key_t       shadow_keys[CAPACITY];
		int         shadow_count;
		set_reply_t pending_replies[$];
		int         mismatches;
		int         printed;

		function new();
			shadow_count = 0;
			mismatches = 0;
			printed = 0;
		endfunction

		function key_t pack_word(set_word_t wd);
			return {wd.fmt, wd.x[10:5], wd.y[10:5], wd.w[10:5], wd.h[10:5]};
		endfunction

		function int find_key(key_t k);
			for (int i = 0; i < shadow_count; i++) begin
				if (shadow_keys[i] == k) begin
					return i;
				end
			end
			return -1;
		endfunction

		function void push_reply(logic p, logic a, logic o, logic v, key_t k, logic l);
			set_reply_t r;
			r = '0;
			r.present = p;
			r.accepted = a;
			r.overflow = o;
			r.entry_count = shadow_count[CNT_W-1:0];
			r.entry_valid = v;
			if (v) begin
				r.fmt = k[26:24];
				r.x = {k[23:18], 5'b0};
				r.y = {k[17:12], 5'b0};
				r.w = {k[11:6], 5'b0};
				r.h = {k[5:0], 5'b0};
			end
			r.last = l;
			pending_replies.push_back(r);
		endfunction

		function void note_command(set_word_t wd);
			key_t k;
			int   pos;
			logic hit;
			k = pack_word(wd);
			pos = find_key(k);
			hit = (pos >= 0);
			case (wd.mode)
				MODE_CONTAINS: begin
					push_reply(hit, 1'b0, 1'b0, 1'b0, '0, 1'b1);
				end
				MODE_ADD: begin
					if (hit) begin
						push_reply(1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b1);
					end else if (shadow_count < CAPACITY) begin
						shadow_keys[shadow_count] = k;
						shadow_count++;
						push_reply(1'b0, 1'b1, 1'b0, 1'b0, '0, 1'b1);
					end else begin
						push_reply(1'b0, 1'b0, 1'b1, 1'b0, '0, 1'b1);
					end
				end
				MODE_REMOVE: begin
					if (hit) begin
						for (int i = pos + 1; i < shadow_count; i++) begin
							shadow_keys[i-1] = shadow_keys[i];
						end
						shadow_count--;
					end
					push_reply(hit, hit, 1'b0, 1'b0, '0, 1'b1);
				end
				MODE_LIST: begin
					if (shadow_count == 0) begin
						push_reply(1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
					end else begin
						for (int i = 0; i < shadow_count; i++) begin
							push_reply(1'b0, 1'b0, 1'b0, 1'b1, shadow_keys[i],
								i == shadow_count - 1);
						end
					end
				end
				MODE_CLEAR: begin
					shadow_count = 0;
					push_reply(1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
				end
				default: begin
					push_reply(1'b0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
				end
			endcase
		endfunction

		task report(string msg);
			mismatches++;
			if (printed < 40) begin
				$display("mismatch at %0t: %s", $realtime, msg);
				printed++;
			end
		endtask

		task check_reply(set_reply_t got);
			set_reply_t want;
			if (pending_replies.size() == 0) begin
				report("result word with no expected word pending");
				return;
			end
			want = pending_replies.pop_front();
			if (got.present !== want.present)
				report($sformatf("present got %0h expected %0h", got.present, want.present));
			if (got.accepted !== want.accepted)
				report($sformatf("accepted got %0h expected %0h", got.accepted, want.accepted));
			if (got.overflow !== want.overflow)
				report($sformatf("overflow got %0h expected %0h", got.overflow, want.overflow));
			if (got.entry_count !== want.entry_count)
				report($sformatf("entry_count got %0h expected %0h",
					got.entry_count, want.entry_count));
			if (got.entry_valid !== want.entry_valid)
				report($sformatf("entry_valid got %0h expected %0h",
					got.entry_valid, want.entry_valid));
			if (got.fmt !== want.fmt)
				report($sformatf("out_format got %0h expected %0h", got.fmt, want.fmt));
			if (got.x !== want.x)
				report($sformatf("out_x got %0h expected %0h", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("out_y got %0h expected %0h", got.y, want.y));
			if (got.w !== want.w)
				report($sformatf("out_w got %0h expected %0h", got.w, want.w));
			if (got.h !== want.h)
				report($sformatf("out_h got %0h expected %0h", got.h, want.h));
			if (got.last !== want.last)
				report($sformatf("last got %0h expected %0h", got.last, want.last));
		endtask

		function int pending();
			return pending_replies.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [MODE_W-1:0] mode = '0;
	logic [FMT_W-1:0]  tex_format = '0;
	logic [DIM_W-1:0]  pos_x = '0;
	logic [DIM_W-1:0]  pos_y = '0;
	logic [DIM_W-1:0]  size_w = '0;
	logic [DIM_W-1:0]  size_h = '0;
	logic              busy;
	logic              result_strobe;
	logic              present;
	logic              accepted;
	logic              overflow;
	logic [CNT_W-1:0]  entry_count;
	logic              entry_valid;
	logic [FMT_W-1:0]  out_format;
	logic [DIM_W-1:0]  out_x;
	logic [DIM_W-1:0]  out_y;
	logic [DIM_W-1:0]  out_w;
	logic [DIM_W-1:0]  out_h;
	logic              last;

	reference_set_tracker tracker;
	set_reply_t           seen;
	int                   quiet_cycles = 0;
	logic                 idle_on = 1'b1;
	logic [5:0]           pool_x[POOL_MAX];
	logic [5:0]           pool_y[POOL_MAX];
	logic [5:0]           pool_w[POOL_MAX];
	logic [5:0]           pool_h[POOL_MAX];
	logic [FMT_W-1:0]     pool_fmt[POOL_MAX];
	int                   pool_size = 1;
	set_word_t            anchor;

	texture_reference_set dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.tex_format(tex_format),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.size_w(size_w),
		.size_h(size_h),
		.result_strobe(result_strobe),
		.present(present),
		.accepted(accepted),
		.overflow(overflow),
		.entry_count(entry_count),
		.entry_valid(entry_valid),
		.out_format(out_format),
		.out_x(out_x),
		.out_y(out_y),
		.out_w(out_w),
		.out_h(out_h),
		.last(last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			seen = {present, accepted, overflow, entry_count, entry_valid, out_format,
				out_x, out_y, out_w, out_h, last};
			tracker.check_reply(seen);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_strobe) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic set_word_t word_of(logic [MODE_W-1:0] m, logic [FMT_W-1:0] f,
		logic [DIM_W-1:0] x, logic [DIM_W-1:0] y, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		set_word_t wd;
		wd.mode = m;
		wd.fmt = f;
		wd.x = x;
		wd.y = y;
		wd.w = w;
		wd.h = h;
		return wd;
	endfunction

	function automatic set_word_t random_word(logic [MODE_W-1:0] m);
		logic [31:0] r1;
		logic [31:0] r2;
		r1 = $urandom();
		r2 = $urandom();
		return word_of(m, r1[2:0], r1[13:3], r1[24:14], r2[10:0], r2[21:11]);
	endfunction

	function automatic set_word_t pool_word(logic [MODE_W-1:0] m);
		int          j;
		logic [31:0] r;
		j = $urandom_range(pool_size - 1);
		r = $urandom();
		return word_of(m, pool_fmt[j], {pool_x[j], r[4:0]}, {pool_y[j], r[9:5]},
			{pool_w[j], r[14:10]}, {pool_h[j], r[19:15]});
	endfunction

	function automatic logic [MODE_W-1:0] pick_mode();
		int r;
		r = $urandom_range(99);
		if (r < 20) return MODE_CONTAINS;
		if (r < 55) return MODE_ADD;
		if (r < 80) return MODE_REMOVE;
		if (r < 88) return MODE_LIST;
		if (r < 93) return MODE_CLEAR;
		if (r < 95) return MODE_UNUSED_LO;
		if (r < 97) return MODE_UNUSED_MID;
		return MODE_UNUSED_HI;
	endfunction

	task automatic fill_pool(int n);
		logic [31:0] r;
		pool_size = n;
		for (int j = 0; j < n; j++) begin
			r = $urandom();
			pool_fmt[j] = r[2:0];
			pool_x[j] = r[8:3];
			pool_y[j] = r[14:9];
			pool_w[j] = r[20:15];
			pool_h[j] = r[26:21];
		end
	endtask

	task automatic send_word(set_word_t wd);
		int gap;
		if (idle_on && $urandom_range(99) < 37) begin
			start <= 1'b0;
			gap = $urandom_range(4, 1);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= wd.mode;
		tex_format <= wd.fmt;
		pos_x <= wd.x;
		pos_y <= wd.y;
		size_w <= wd.w;
		size_h <= wd.h;
		do @(posedge clk); while (busy);
		tracker.note_command(wd);
	endtask

	task automatic mixed_run(int n, int psize);
		logic [MODE_W-1:0] m;
		fill_pool(psize);
		repeat (n) begin
			m = pick_mode();
			if ($urandom_range(99) < 85) begin
				send_word(pool_word(m));
			end else begin
				send_word(random_word(m));
			end
		end
	endtask

	task automatic fill_to_capacity();
		int guard;
		guard = 0;
		while (tracker.shadow_count < CAPACITY && guard < 4 * CAPACITY) begin
			send_word(random_word(MODE_ADD));
			guard++;
		end
	endtask

	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(word_of(MODE_LIST, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));
		send_word(word_of(MODE_CONTAINS, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));
		send_word(word_of(MODE_REMOVE, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));
		send_word(word_of(MODE_ADD, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));
		send_word(word_of(MODE_ADD, 3'd7, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF));
		send_word(word_of(MODE_ADD, 3'd7, 11'h7E0, 11'h7FF, 11'h7EF, 11'h7F0));
		send_word(word_of(MODE_CONTAINS, 3'd7, 11'h7E0, 11'h7E0, 11'h7E0, 11'h7E0));
		send_word(word_of(MODE_ADD, 3'd3, 11'h020, 11'h01F, 11'h400, 11'h555));
		send_word(word_of(MODE_LIST, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));
		send_word(word_of(MODE_REMOVE, 3'd0, 11'h01F, 11'h00A, 11'h015, 11'h01F));
		send_word(word_of(MODE_LIST, 3'd7, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF));
		send_word(word_of(MODE_REMOVE, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));
		send_word(word_of(MODE_CONTAINS, 3'd3, 11'h03F, 11'h000, 11'h41F, 11'h540));
		send_word(word_of(MODE_UNUSED_LO, 3'd7, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF));
		send_word(word_of(MODE_UNUSED_MID, 3'd3, 11'h020, 11'h01F, 11'h400, 11'h555));
		send_word(word_of(MODE_UNUSED_HI, 3'd5, 11'h2AA, 11'h555, 11'h2AA, 11'h555));
		send_word(word_of(MODE_ADD, 3'd5, 11'h2AA, 11'h555, 11'h2AA, 11'h555));
		send_word(word_of(MODE_REMOVE, 3'd7, 11'h7FF, 11'h7E0, 11'h7FF, 11'h7E0));
		send_word(word_of(MODE_LIST, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));
		send_word(word_of(MODE_CLEAR, 3'd6, 11'h555, 11'h2AA, 11'h555, 11'h2AA));
		send_word(word_of(MODE_LIST, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));
		send_word(word_of(MODE_CONTAINS, 3'd5, 11'h2AA, 11'h555, 11'h2AA, 11'h555));
		send_word(word_of(MODE_ADD, 3'd0, 11'h01F, 11'h01F, 11'h01F, 11'h01F));
		send_word(word_of(MODE_LIST, 3'd0, 11'h000, 11'h000, 11'h000, 11'h000));

		mixed_run(55, 6);

		// Fill the set to capacity with no idle cycles, then work it while full.
		idle_on = 1'b0;
		send_word(random_word(MODE_CLEAR));
		anchor = random_word(MODE_ADD);
		send_word(anchor);
		fill_to_capacity();
		send_word(random_word(MODE_ADD));
		send_word(random_word(MODE_ADD));
		anchor.mode = MODE_ADD;
		anchor.x[4:0] = ~anchor.x[4:0];
		send_word(anchor);
		anchor.mode = MODE_CONTAINS;
		send_word(anchor);
		send_word(random_word(MODE_LIST));
		anchor.mode = MODE_REMOVE;
		send_word(anchor);
		send_word(random_word(MODE_LIST));
		fill_to_capacity();
		send_word(random_word(MODE_ADD));
		idle_on = 1'b1;

		mixed_run(55, 4);
		mixed_run(55, 12);
		mixed_run(55, 16);

		start <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/trs_pkg.sv
src/trs_ctrl.sv
src/trs_dp.sv
src/texture_reference_set.sv
tb/texture_reference_set_tb.sv
